[rtl/pssh_pkg.sv]
`timescale 1ns / 1ps
package pssh_pkg;

    localparam int LEN_W      = 31;
    localparam int BOX_LEN_W  = 32;
    localparam int DATA_W     = 8;
    localparam int CFG_W      = 64;
    localparam int ADDR_W     = 4;

    localparam logic [BOX_LEN_W-1:0] PAYLOAD_OFFSET_IN_BOX = 32'd32;
    localparam logic [LEN_W-1:0] HDR_BYTES    = 31'd4;
    localparam logic [LEN_W-1:0] HDR_LAST     = 31'd3;
    localparam logic [LEN_W-1:0] ID_FIRST_OFF = 31'd12;
    localparam logic [LEN_W-1:0] ID_END_OFF   = 31'd28;
    localparam logic [LEN_W-1:0] ID_LAST_OFF  = 31'd27;
    localparam logic [3:0]       ID_BASE      = 4'd12;

    // register index is taken from paddr[3] (registers sit 8 bytes apart)
    localparam logic REG_ID_HIGH = 1'b0;
    localparam logic REG_ID_LOW  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_SHORT     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    function automatic logic [DATA_W-1:0] id_byte(
        input logic [CFG_W-1:0] id_high,
        input logic [CFG_W-1:0] id_low,
        input logic [3:0]       idx
    );
        logic [2*CFG_W-1:0] id;
        logic [3:0]         rev;
        id  = {id_high, id_low};
        rev = 4'd15 - idx;
        return id[{rev, 3'b000} +: DATA_W];
    endfunction

endpackage

[rtl/pssh_in_if.sv]
`timescale 1ns / 1ps
interface pssh_in_if;
    logic                           valid;
    logic                           ready;
    logic [pssh_pkg::DATA_W-1:0]    data_byte;
    logic                           first_byte;
    logic [pssh_pkg::LEN_W-1:0]     total_length;

    modport source (output valid, output data_byte, output first_byte,
                    output total_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input total_length, output ready);
endinterface

[rtl/pssh_out_if.sv]
`timescale 1ns / 1ps
interface pssh_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [pssh_pkg::LEN_W-1:0]     payload_offset;
    logic [pssh_pkg::LEN_W-1:0]     payload_length;

    modport source (output valid, output status, output payload_offset,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input payload_offset,
                    input payload_length, output ready);
endinterface

[rtl/pssh_box_payload_finder.sv]
`timescale 1ns / 1ps
// A result is registered: the byte that causes it passes the input register,
// then the result register.
// Throughput: one byte per cycle; the only stall is a held result on rsp.
// Reset (rst_n, async, active low): system ID registers clear to zero and the
// search sits idle, ignoring bytes until one arrives with first_byte set.
module pssh_box_payload_finder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pssh_pkg::ADDR_W-1:0]     paddr,
    input  logic [pssh_pkg::CFG_W-1:0]      pwdata,
    output logic [pssh_pkg::CFG_W-1:0]      prdata,
    output logic                            pready,
    pssh_in_if.sink                         req,
    pssh_out_if.source                      rsp
);
    import pssh_pkg::*;

    // configuration
    logic [CFG_W-1:0] id_high_reg;
    logic [CFG_W-1:0] id_low_reg;
    logic             cfg_write;

    // input stage
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_first_reg;
    logic [LEN_W-1:0]  in_total_reg;

    // search state
    logic [LEN_W-1:0]     off_reg,   off_next;
    logic [LEN_W-1:0]     start_reg, start_next;
    logic [LEN_W-1:0]     rem_reg,   rem_next;
    logic [BOX_LEN_W-1:0] len_reg,   len_next;
    logic                 match_reg, match_next;
    logic                 done_reg,  done_next;

    // result stage
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [LEN_W-1:0] out_offset_reg;
    logic [LEN_W-1:0] out_length_reg;

    logic                 proceed;
    logic                 active;
    logic                 emit;
    status_t              emit_status;
    logic [LEN_W-1:0]     emit_offset;
    logic [LEN_W-1:0]     emit_length;
    logic [LEN_W-1:0]     eff_off;
    logic [LEN_W-1:0]     eff_start;
    logic [LEN_W-1:0]     eff_rem;
    logic [BOX_LEN_W-1:0] eff_len;
    logic                 eff_match;
    logic [BOX_LEN_W-1:0] hdr_len;
    logic                 in_window;
    logic                 byte_ok;
    logic                 match_now;
    logic [LEN_W-1:0]     rem_after;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_ID_LOW) ? id_low_reg : id_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg <= '0;
            id_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_ID_LOW)
                id_low_reg <= pwdata;
            else
                id_high_reg <= pwdata;
        end
    end

    assign proceed   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg  <= req.data_byte;
            in_first_reg <= req.first_byte;
            in_total_reg <= req.total_length;
        end
    end

    // a first byte restarts the search with fresh state in the same cycle
    assign active    = in_first_reg || !done_reg;
    assign eff_off   = in_first_reg ? '0           : off_reg;
    assign eff_start = in_first_reg ? '0           : start_reg;
    assign eff_rem   = in_first_reg ? in_total_reg : rem_reg;
    assign eff_len   = in_first_reg ? '0           : len_reg;
    assign eff_match = in_first_reg ? 1'b1         : match_reg;

    assign hdr_len   = {eff_len[BOX_LEN_W-DATA_W-1:0], in_data_reg};
    assign in_window = (eff_off >= ID_FIRST_OFF) && (eff_off < ID_END_OFF);
    assign byte_ok   = in_data_reg == id_byte(id_high_reg, id_low_reg, eff_off[3:0] - ID_BASE);
    assign match_now = eff_match && (byte_ok || !in_window);
    assign rem_after = eff_rem - eff_len[LEN_W-1:0];

    always_comb
    begin
        off_next    = off_reg;
        start_next  = start_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        match_next  = match_reg;
        done_next   = done_reg;
        emit        = 1'b0;
        emit_status = STATUS_NOT_FOUND;
        emit_offset = '0;
        emit_length = '0;

        if (proceed && active)
        begin
            off_next   = eff_off + 31'd1;
            start_next = eff_start;
            rem_next   = eff_rem;
            len_next   = eff_len;
            match_next = eff_match;
            done_next  = 1'b0;

            if (in_first_reg && (in_total_reg < HDR_BYTES))
            begin
                emit = 1'b1;
            end
            else if (eff_off < HDR_BYTES)
            begin
                len_next = hdr_len;
                if (eff_off == HDR_LAST)
                begin
                    if (hdr_len > {1'b0, eff_rem})
                    begin
                        emit        = 1'b1;
                        emit_status = STATUS_MALFORMED;
                    end
                    else if (hdr_len < PAYLOAD_OFFSET_IN_BOX)
                    begin
                        emit        = 1'b1;
                        emit_status = STATUS_SHORT;
                    end
                end
            end
            else
            begin
                match_next = match_now;
                if (in_window && (eff_off == ID_LAST_OFF) && match_now)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_FOUND;
                    emit_offset = eff_start + PAYLOAD_OFFSET_IN_BOX[LEN_W-1:0];
                    emit_length = eff_len[LEN_W-1:0] - PAYLOAD_OFFSET_IN_BOX[LEN_W-1:0];
                end
                else if (({1'b0, eff_off} + 32'd1) == eff_len)
                begin
                    // end of box: step to the next one
                    off_next   = '0;
                    start_next = eff_start + eff_len[LEN_W-1:0];
                    rem_next   = rem_after;
                    len_next   = '0;
                    match_next = 1'b1;
                    if (rem_after < HDR_BYTES)
                        emit = 1'b1;
                end
            end

            if (emit)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            start_reg <= '0;
            rem_reg   <= '0;
            len_reg   <= '0;
            match_reg <= 1'b1;
            done_reg  <= 1'b1;
        end
        else
        begin
            off_reg   <= off_next;
            start_reg <= start_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            match_reg <= match_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proceed && emit)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            out_status_reg <= emit_status;
            out_offset_reg <= emit_offset;
            out_length_reg <= emit_length;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.payload_offset = out_offset_reg;
    assign rsp.payload_length = out_length_reg;

`ifndef SYNTHESIS
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && done_reg && !in_first_reg) |-> !emit)
        else $error("result produced while search idle");

    a_emit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && emit) |=> (done_reg && out_valid_reg))
        else $error("result did not end the search");

    a_miss_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_FOUND))
            |-> (out_offset_reg == '0 && out_length_reg == '0))
        else $error("non-found result carries payload fields");

    a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STATUS_FOUND))
            |-> (out_offset_reg >= PAYLOAD_OFFSET_IN_BOX[LEN_W-1:0]))
        else $error("found payload offset before end of box header");
`endif

endmodule
